[hdl/fdsf_pkg.sv]
package fdsf_pkg;

	localparam int WORD_W = 32;
	localparam int COL_N = 6;
	localparam int TERM_W = 38;
	localparam int SUM_W = 41;
	localparam int FRAME_NUMBER_W = 16;
	localparam int FRAME_INDEX_BITS_DEF = 16;
	localparam int CFG_INDEX_W = 2;

	// Arc length on a 50 mm sphere per degree, as an unsigned Q0.32 fraction.
	localparam logic [WORD_W-1:0] DEG_SCALE_Q32 = 32'd3748066029;
	localparam logic [TERM_W-1:0] RAD_SCALE = 38'd50;

	localparam logic [CFG_INDEX_W-1:0] REG_FD_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DVARS_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_FORMAT = 2'd2;

	localparam logic FMT_DEGREES = 1'b0;
	localparam logic FMT_RADIANS = 1'b1;

	localparam logic [WORD_W-1:0] THRESHOLD_RESET = 32'h0000_8000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COL_N-1:0][WORD_W-1:0] col_vec_t;
	typedef logic [COL_N-1:0][TERM_W-1:0] term_vec_t;

	typedef struct packed {
		logic [FRAME_NUMBER_W-1:0] frame_number;
		logic [WORD_W-1:0]         displacement;
		logic                      scrub;
		logic                      run_end;
	} result_t;

	// Up to two results per frame; the second one is only ever used with the first.
	typedef struct packed {
		logic    first;
		logic    second;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

[hdl/framewise_displacement_scrub_flagger.sv]
// Channel   Direction  Handshake                    Carries
// item      in         item_valid / item_ready      six motion columns, DVARS, final flag
// result    out        result_valid / result_ready  frame number, displacement, scrub, run end
// cfg       in         cfg_we (no wait)             threshold and column format writes
//
// A frame is taken every cycle while the queue has two free slots. It passes an input
// register, a stage of per-column multipliers, a summing stage and the flagging logic,
// and its results land in a four-entry result queue. A final frame writes two results
// at once. Reset clears the run state, the queue and the configuration to its reset
// values; there is no clearing pass. The pipeline moves as a whole whenever the queue
// has two free slots, so item_ready never depends on result_ready within the same cycle.
module framewise_displacement_scrub_flagger import fdsf_pkg::*; #(
	parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic signed [WORD_W-1:0]  motion_col_1,
	input  logic signed [WORD_W-1:0]  motion_col_2,
	input  logic signed [WORD_W-1:0]  motion_col_3,
	input  logic signed [WORD_W-1:0]  motion_col_4,
	input  logic signed [WORD_W-1:0]  motion_col_5,
	input  logic signed [WORD_W-1:0]  motion_col_6,
	input  logic [WORD_W-1:0]         dvars_value,
	input  logic                      final_frame,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [FRAME_NUMBER_W-1:0] frame_number,
	output logic [WORD_W-1:0]         displacement,
	output logic                      scrub,
	output logic                      run_end,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [WORD_W-1:0]         cfg_data
);

	// Configuration registers; the user must write them only while the block is idle.
	logic [WORD_W-1:0] fd_threshold_q;
	logic [WORD_W-1:0] dvars_threshold_q;
	logic              column_format_q;

	// The pipeline advances only when the result queue can absorb a final frame.
	logic              adv;
	logic              item_accept;
	col_vec_t          cols;
	term_vec_t         term_s2;
	logic [WORD_W-1:0] dvars_s2;
	logic              final_s2;
	logic              vld_s2;
	logic [WORD_W-1:0] fd_s3;
	logic [WORD_W-1:0] dvars_s3;
	logic              final_s3;
	logic              vld_s3;
	push_t             push;
	result_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_threshold_q    <= THRESHOLD_RESET;
			dvars_threshold_q <= THRESHOLD_RESET;
			column_format_q   <= FMT_DEGREES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FD_THRESHOLD:    fd_threshold_q <= cfg_data;
				REG_DVARS_THRESHOLD: dvars_threshold_q <= cfg_data;
				REG_COLUMN_FORMAT:   column_format_q <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	assign item_ready = adv;
	assign item_accept = item_valid && adv;

	// Column 1 sits in the lowest slot of the packed vector.
	assign cols = {motion_col_6, motion_col_5, motion_col_4,
	               motion_col_3, motion_col_2, motion_col_1};

	fdsf_terms u_terms (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item_accept (item_accept),
		.col_format  (column_format_q),
		.cols        (cols),
		.dvars       (dvars_value),
		.final_in    (final_frame),
		.term_s2     (term_s2),
		.dvars_s2    (dvars_s2),
		.final_s2    (final_s2),
		.vld_s2      (vld_s2)
	);

	fdsf_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.term_s2  (term_s2),
		.dvars_s2 (dvars_s2),
		.final_s2 (final_s2),
		.vld_s2   (vld_s2),
		.fd_s3    (fd_s3),
		.dvars_s3 (dvars_s3),
		.final_s3 (final_s3),
		.vld_s3   (vld_s3)
	);

	// The flagging stage holds the run state and emits the delayed result of the
	// previous frame, plus the result of the frame itself when it closes the run.
	fdsf_flag #(
		.FRAME_INDEX_BITS (FRAME_INDEX_BITS)
	) u_flag (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.vld_s3          (vld_s3),
		.fd_s3           (fd_s3),
		.dvars_s3        (dvars_s3),
		.final_s3        (final_s3),
		.fd_threshold    (fd_threshold_q),
		.dvars_threshold (dvars_threshold_q),
		.push            (push)
	);

	fdsf_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.head         (head),
		.room         (adv)
	);

	assign frame_number = head.frame_number;
	assign displacement = head.displacement;
	assign scrub = head.scrub;
	assign run_end = head.run_end;

endmodule

[hdl/fdsf_terms.sv]
module fdsf_terms import fdsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              item_accept,
	input  logic              col_format,
	input  col_vec_t          cols,
	input  logic [WORD_W-1:0] dvars,
	input  logic              final_in,
	output term_vec_t         term_s2,
	output logic [WORD_W-1:0] dvars_s2,
	output logic              final_s2,
	output logic              vld_s2
);

	col_vec_t          cur_s1;
	col_vec_t          prv_s1;
	col_vec_t          prev_q;
	logic [WORD_W-1:0] dvars_s1;
	logic              final_s1;
	logic              vld_s1;
	term_vec_t         term_d;

	// One magnitude per column, scaled where the column holds a rotation; each column has its own multipliers.
	for (genvar i = 0; i < COL_N; i++) begin : g_col
		logic signed [WORD_W:0] diff;
		logic [WORD_W:0]        neg;
		logic [WORD_W-1:0]      mag;
		logic [2*WORD_W-1:0]    deg_prod;
		logic [2*WORD_W-1:0]    deg_rnd;
		logic [TERM_W-1:0]      rad_prod;
		logic                   rot;

		always_comb begin
			diff = $signed({cur_s1[i][WORD_W-1], cur_s1[i]})
			     - $signed({prv_s1[i][WORD_W-1], prv_s1[i]});
			neg = -diff;
			mag = diff[WORD_W] ? neg[WORD_W-1:0] : diff[WORD_W-1:0];
			deg_prod = {{WORD_W{1'b0}}, mag} * {{WORD_W{1'b0}}, DEG_SCALE_Q32};
			deg_rnd = deg_prod + {{(WORD_W+1){1'b0}}, {(WORD_W-1){1'b0}}} + 64'h8000_0000;
			rad_prod = TERM_W'(mag) * RAD_SCALE;
			if (col_format == FMT_RADIANS) begin
				rot = (i < COL_N / 2);
			end else begin
				rot = (i >= COL_N / 2);
			end
			if (!rot) begin
				term_d[i] = TERM_W'(mag);
			end else if (col_format == FMT_RADIANS) begin
				term_d[i] = rad_prod;
			end else begin
				term_d[i] = TERM_W'(deg_rnd[2*WORD_W-1:WORD_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (item_accept) begin
				cur_s1   <= cols;
				prv_s1   <= prev_q;
				prev_q   <= cols;
				dvars_s1 <= dvars;
				final_s1 <= final_in;
			end
			term_s2  <= term_d;
			dvars_s2 <= dvars_s1;
			final_s2 <= final_s1;
		end
	end

endmodule

[hdl/fdsf_sum.sv]
module fdsf_sum import fdsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  term_vec_t         term_s2,
	input  logic [WORD_W-1:0] dvars_s2,
	input  logic              final_s2,
	input  logic              vld_s2,
	output logic [WORD_W-1:0] fd_s3,
	output logic [WORD_W-1:0] dvars_s3,
	output logic              final_s3,
	output logic              vld_s3
);

	logic [SUM_W-1:0]  sum;
	logic [WORD_W-1:0] fd_d;

	always_comb begin
		sum = '0;
		for (int i = 0; i < COL_N; i++) begin
			sum = sum + SUM_W'(term_s2[i]);
		end
		fd_d = (|sum[SUM_W-1:WORD_W]) ? '1 : sum[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s3    <= fd_d;
			dvars_s3 <= dvars_s2;
			final_s3 <= final_s2;
		end
	end

endmodule

[hdl/fdsf_flag.sv]
module fdsf_flag import fdsf_pkg::*; #(
	parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_s3,
	input  logic [WORD_W-1:0] fd_s3,
	input  logic [WORD_W-1:0] dvars_s3,
	input  logic              final_s3,
	input  logic [WORD_W-1:0] fd_threshold,
	input  logic [WORD_W-1:0] dvars_threshold,
	output push_t             push
);

	logic                        have_q;
	logic [WORD_W-1:0]           pend_q;
	logic                        prev_hit_q;
	logic                        hbp_q;
	logic [FRAME_INDEX_BITS-1:0] cnt_q;

	logic                        have_n;
	logic [WORD_W-1:0]           pend_n;
	logic                        prev_hit_n;
	logic                        hbp_n;
	logic [FRAME_INDEX_BITS-1:0] cnt_n;
	logic [FRAME_INDEX_BITS-1:0] prev_idx;
	logic                        hit;
	logic                        take;

	always_comb begin
		take = adv && vld_s3;
		hit = (fd_s3 > fd_threshold) || (dvars_s3 > dvars_threshold);
		prev_idx = cnt_q - {{(FRAME_INDEX_BITS-1){1'b0}}, 1'b1};
		push = '0;
		have_n = have_q;
		pend_n = pend_q;
		prev_hit_n = prev_hit_q;
		hbp_n = hbp_q;
		cnt_n = cnt_q;
		if (take) begin
			if (!have_q) begin
				if (final_s3) begin
					// A run of a single frame.
					push.first = 1'b1;
					push.r0.run_end = 1'b1;
				end else begin
					have_n = 1'b1;
					pend_n = '0;
					prev_hit_n = 1'b0;
					hbp_n = 1'b0;
					cnt_n = FRAME_INDEX_BITS'(1);
				end
			end else begin
				push.first = 1'b1;
				push.r0.frame_number = FRAME_NUMBER_W'(prev_idx);
				push.r0.displacement = pend_q;
				push.r0.scrub = hbp_q || prev_hit_q || hit;
				push.r0.run_end = 1'b0;
				if (final_s3) begin
					push.second = 1'b1;
					push.r1.frame_number = FRAME_NUMBER_W'(cnt_q);
					push.r1.displacement = fd_s3;
					push.r1.scrub = prev_hit_q || hit;
					push.r1.run_end = 1'b1;
					have_n = 1'b0;
					pend_n = '0;
					prev_hit_n = 1'b0;
					hbp_n = 1'b0;
					cnt_n = '0;
				end else begin
					pend_n = fd_s3;
					hbp_n = prev_hit_q;
					prev_hit_n = hit;
					cnt_n = cnt_q + {{(FRAME_INDEX_BITS-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			pend_q     <= '0;
			prev_hit_q <= 1'b0;
			hbp_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			have_q     <= have_n;
			pend_q     <= pend_n;
			prev_hit_q <= prev_hit_n;
			hbp_q      <= hbp_n;
			cnt_q      <= cnt_n;
		end
	end

	a_second_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> (push.first && push.r1.run_end && !push.r0.run_end))
		else $error("second result without a leading result or without run end");

	a_final_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_s3) |=> (!have_q && cnt_q == '0))
		else $error("run state not cleared after the final frame");

endmodule

[hdl/fdsf_outq.sv]
module fdsf_outq import fdsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    result_ready,
	output logic    result_valid,
	output result_t head,
	output logic    room
);

	result_t                  mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_COUNT_W-1:0] count_q;
	logic [QUEUE_PTR_W-1:0]   wr_ptr_2;
	logic                     pop;

	assign result_valid = (count_q != '0);
	assign head = mem[rd_ptr_q];
	assign pop = result_valid && result_ready;
	assign room = (count_q <= QUEUE_COUNT_W'(QUEUE_DEPTH - 2));
	assign wr_ptr_2 = wr_ptr_q + {{(QUEUE_PTR_W-1){1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.second) begin
			mem[wr_ptr_2] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(push.first) + QUEUE_PTR_W'(push.second);
			rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(pop);
			count_q  <= count_q + QUEUE_COUNT_W'(push.first) + QUEUE_COUNT_W'(push.second)
			          - QUEUE_COUNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_COUNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> room)
		else $error("result written without two free slots");

endmodule
